[hw/rtl/pstt_pkg.sv]
`default_nettype none
package pstt_pkg;

  localparam int MAX_SUBS_DEF  = 16;
  localparam int TOPIC_LEN_DEF = 256;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_DONE    = 1'b1;

  typedef enum logic [1:0] {
    FN_SUB   = 2'd0,
    FN_UNSUB = 2'd1,
    FN_PUB   = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    STS_ADDED   = 3'd0,
    STS_PRESENT = 3'd1,
    STS_FULL    = 3'd2,
    STS_UNSUBD  = 3'd3,
    STS_PUBD    = 3'd4,
    STS_TRUNC   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_CAP,
    S_UNS,
    S_COPY,
    S_PUB,
    S_DONE
  } seq_state_t;

  function automatic logic [4:0] sat_cnt(input logic [7:0] v);
    logic [4:0] r;
    if (v > 8'd31) begin
      r = 5'd31;
    end else begin
      r = v[4:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/pubsub_topic_subscription_table.sv]
`default_nettype none
// Channel  | Direction | Handshake             | Payload
// in_      | input     | in_valid / in_ready   | func, topic_char, topic_last, client_ip, port
// out_     | output    | out_valid / out_ready | kind, dest_ip, dest_port, status, count, run_last
//
// Topic characters are taken one per cycle while in_ready is high, which is only in the idle state.
// The last character of a subscribe, unsubscribe or publish whose topic is not truncated starts a
// scan that streams the topic through the row of cells, one cell per cycle, fed by the
// one-character-per-cycle walk over each cell's topic memory. Subscribe then copies the topic in,
// unsubscribe copies the last entry over each removed one, and publish steps through every entry.
// Reset is synchronous and active low; a stalled out_ready holds the sequencer.
module pubsub_topic_subscription_table #(
  parameter int MAX_SUBS  = pstt_pkg::MAX_SUBS_DEF,
  parameter int TOPIC_LEN = pstt_pkg::TOPIC_LEN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_func,
  input  wire logic [7:0]  in_topic_char,
  input  wire logic        in_topic_last,
  input  wire logic [31:0] in_client_ip,
  input  wire logic [15:0] in_client_port,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic      [31:0] out_dest_ip,
  output logic      [15:0] out_dest_port,
  output logic      [2:0]  out_status,
  output logic      [4:0]  out_count,
  output logic             out_run_last
);
  import pstt_pkg::*;

  localparam int LW = $clog2(TOPIC_LEN);
  localparam int CW = $clog2(MAX_SUBS + 1);
  localparam int IW = (MAX_SUBS > 1) ? $clog2(MAX_SUBS) : 1;
  localparam logic [LW-1:0] LAST_POS = LW'(TOPIC_LEN - 1);
  localparam logic [LW-1:0] SCAN_END = LW'(TOPIC_LEN - 2);
  localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_SUBS);

  seq_state_t    state_r, state_nxt;
  logic [LW-1:0] len_r;
  logic          trunc_r;
  func_t         func_r;
  logic [31:0]   ip_r;
  logic [15:0]   port_r;
  logic [CW-1:0] cnt_r, u_r, res_r;
  logic [LW-1:0] gen_r, cp_r;
  logic [IW-1:0] src_r, dst_r;
  logic          cp_sub_r;
  logic [MAX_SUBS-1:0] same_v_r, hit_v_r;
  status_t       done_st_r;
  logic          t0_v_r, t0_fin_r;
  logic [LW-1:0] t0_idx_r;
  logic [7:0]    buf_mem [TOPIC_LEN];
  logic [7:0]    buf_rd_r;

  logic          out_valid_r, out_kind_r, out_run_last_r;
  logic [31:0]   out_ip_r;
  logic [15:0]   out_port_r;
  logic [2:0]    out_status_r;
  logic [4:0]    out_count_r;

  logic          ch_v   [MAX_SUBS+1];
  logic [LW-1:0] ch_idx [MAX_SUBS+1];
  logic [7:0]    ch_c   [MAX_SUBS+1];
  logic          ch_fin [MAX_SUBS+1];
  logic [7:0]    c_rd   [MAX_SUBS];
  logic [LW-1:0] c_len  [MAX_SUBS];
  logic [31:0]   c_ip   [MAX_SUBS];
  logic [15:0]   c_port [MAX_SUBS];
  logic [MAX_SUBS-1:0] c_same, c_hit, mask;

  logic          in_fire, can_out, trunc_now, u_live, found, chain_fin;
  logic [IW-1:0] u_idx, l_idx;
  logic [CW-1:0] last_e;
  logic          emit_deliv, emit_done, cp_wr, cp_end;
  logic [7:0]    wr_data;
  logic [LW-1:0] meta_len;
  logic [31:0]   meta_ip;
  logic [15:0]   meta_port;

  assign in_ready  = state_r == S_IDLE;
  assign in_fire   = in_valid && in_ready;
  assign can_out   = !out_valid_r || out_ready;
  assign trunc_now = trunc_r || (len_r == LAST_POS);
  assign u_idx     = u_r[IW-1:0];
  assign last_e    = cnt_r - CW'(1);
  assign l_idx     = last_e[IW-1:0];
  assign u_live    = u_r < cnt_r;
  assign chain_fin = ch_v[MAX_SUBS] && ch_fin[MAX_SUBS];

  always_comb begin
    for (int k = 0; k < MAX_SUBS; k++) begin
      mask[k] = CW'(k) < cnt_r;
    end
  end
  assign found = |(c_same & mask);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_topic_last) begin
          if (func_t'(in_func) == FN_NONE) begin
            state_nxt = S_IDLE;
          end else if (trunc_now) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (gen_r == SCAN_END) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (chain_fin) begin
          state_nxt = S_CAP;
        end
      end
      S_CAP: begin
        unique case (func_r)
          FN_SUB:   state_nxt = (!found && cnt_r < CNT_MAX) ? S_COPY : S_DONE;
          FN_UNSUB: state_nxt = S_UNS;
          FN_PUB:   state_nxt = S_PUB;
          default:  state_nxt = S_DONE;
        endcase
      end
      S_UNS: begin
        if (!u_live) begin
          state_nxt = S_DONE;
        end else if (same_v_r[u_idx] && last_e != u_r) begin
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        if (cp_r == LAST_POS) begin
          state_nxt = cp_sub_r ? S_DONE : S_UNS;
        end
      end
      S_PUB: begin
        if (!u_live) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (can_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    emit_deliv = (state_r == S_PUB) && u_live && hit_v_r[u_idx] && can_out;
    emit_done  = (state_r == S_DONE) && can_out;
    cp_wr      = (state_r == S_COPY) && (cp_r != '0);
    cp_end     = (state_r == S_COPY) && (cp_r == LAST_POS);
    wr_data    = cp_sub_r ? buf_rd_r : c_rd[src_r];
    meta_len   = cp_sub_r ? len_r  : c_len[src_r];
    meta_ip    = cp_sub_r ? ip_r   : c_ip[src_r];
    meta_port  = cp_sub_r ? port_r : c_port[src_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      trunc_r     <= 1'b0;
      cnt_r       <= '0;
      t0_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      t0_v_r  <= state_r == S_SCAN;
      if (in_fire) begin
        if (in_topic_last && func_t'(in_func) == FN_NONE) begin
          len_r   <= '0;
          trunc_r <= 1'b0;
        end else if (len_r < LAST_POS) begin
          len_r <= len_r + LW'(1);
        end else begin
          trunc_r <= 1'b1;
        end
      end else if (emit_done) begin
        len_r   <= '0;
        trunc_r <= 1'b0;
      end
      if (state_r == S_UNS && u_live && same_v_r[u_idx] && last_e == u_r) begin
        cnt_r <= last_e;
      end
      if (cp_end) begin
        cnt_r <= cp_sub_r ? cnt_r + CW'(1) : last_e;
      end
      if (emit_deliv || emit_done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && len_r < LAST_POS) begin
      buf_mem[len_r] <= in_topic_char;
    end
    buf_rd_r <= buf_mem[(state_r == S_SCAN) ? gen_r : cp_r];
  end

  always_ff @(posedge clk) begin
    t0_idx_r <= gen_r;
    t0_fin_r <= gen_r == SCAN_END;
    if (in_fire && in_topic_last) begin
      func_r    <= func_t'(in_func);
      ip_r      <= in_client_ip;
      port_r    <= in_client_port;
      gen_r     <= '0;
      done_st_r <= STS_TRUNC;
      res_r     <= '0;
    end
    if (state_r == S_SCAN) begin
      gen_r <= gen_r + LW'(1);
    end
    if (state_r == S_COPY) begin
      cp_r <= cp_r + LW'(1);
    end
    if (state_r == S_CAP) begin
      same_v_r <= c_same & mask;
      hit_v_r  <= c_hit & mask;
      u_r      <= '0;
      res_r    <= '0;
      cp_r     <= '0;
      dst_r    <= cnt_r[IW-1:0];
      cp_sub_r <= 1'b1;
      unique case (func_r)
        FN_SUB: begin
          if (found) begin
            done_st_r <= STS_PRESENT;
          end else if (cnt_r < CNT_MAX) begin
            done_st_r <= STS_ADDED;
          end else begin
            done_st_r <= STS_FULL;
          end
        end
        FN_UNSUB: done_st_r <= STS_UNSUBD;
        default:  done_st_r <= STS_PUBD;
      endcase
    end
    if (state_r == S_UNS && u_live) begin
      if (same_v_r[u_idx]) begin
        if (last_e == u_r) begin
          res_r <= res_r + CW'(1);
        end else begin
          cp_r             <= '0;
          src_r            <= l_idx;
          dst_r            <= u_idx;
          cp_sub_r         <= 1'b0;
          same_v_r[u_idx]  <= same_v_r[l_idx];
        end
      end else begin
        u_r <= u_r + CW'(1);
      end
    end
    if (cp_end && !cp_sub_r) begin
      res_r <= res_r + CW'(1);
    end
    if (state_r == S_PUB && u_live) begin
      if (!hit_v_r[u_idx]) begin
        u_r <= u_r + CW'(1);
      end else if (can_out) begin
        u_r   <= u_r + CW'(1);
        res_r <= res_r + CW'(1);
      end
    end
    if (emit_deliv) begin
      out_kind_r     <= KIND_DELIVER;
      out_ip_r       <= c_ip[u_idx];
      out_port_r     <= c_port[u_idx];
      out_status_r   <= '0;
      out_count_r    <= '0;
      out_run_last_r <= 1'b0;
    end else if (emit_done) begin
      out_kind_r     <= KIND_DONE;
      out_ip_r       <= '0;
      out_port_r     <= '0;
      out_status_r   <= done_st_r;
      out_count_r    <= sat_cnt(8'(res_r));
      out_run_last_r <= 1'b1;
    end
  end

  assign ch_v[0]   = t0_v_r;
  assign ch_idx[0] = t0_idx_r;
  assign ch_c[0]   = buf_rd_r;
  assign ch_fin[0] = t0_fin_r;

  for (genvar k = 0; k < MAX_SUBS; k++) begin : g_cell
    pstt_cell #(
      .TOPIC_LEN(TOPIC_LEN)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .tv_i       (ch_v[k]),
      .tidx_i     (ch_idx[k]),
      .tch_i      (ch_c[k]),
      .tfin_i     (ch_fin[k]),
      .tv_o       (ch_v[k+1]),
      .tidx_o     (ch_idx[k+1]),
      .tch_o      (ch_c[k+1]),
      .tfin_o     (ch_fin[k+1]),
      .plen_i     (len_r),
      .ip_i       (ip_r),
      .port_i     (port_r),
      .cp_mode_i  (state_r == S_COPY),
      .cp_addr_i  (cp_r),
      .wr_en_i    (cp_wr && dst_r == IW'(k)),
      .wr_addr_i  (cp_r - LW'(1)),
      .wr_data_i  (wr_data),
      .rd_data_o  (c_rd[k]),
      .meta_we_i  (cp_end && dst_r == IW'(k)),
      .meta_len_i (meta_len),
      .meta_ip_i  (meta_ip),
      .meta_port_i(meta_port),
      .meta_len_o (c_len[k]),
      .meta_ip_o  (c_ip[k]),
      .meta_port_o(c_port[k]),
      .same_o     (c_same[k]),
      .hit_o      (c_hit[k])
    );
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_dest_ip   = out_ip_r;
  assign out_dest_port = out_port_r;
  assign out_status    = out_status_r;
  assign out_count     = out_count_r;
  assign out_run_last  = out_run_last_r;

endmodule
`default_nettype wire

[hw/rtl/pstt_cell.sv]
`default_nettype none
module pstt_cell #(
  parameter int TOPIC_LEN = pstt_pkg::TOPIC_LEN_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         tv_i,
  input  wire logic [$clog2(TOPIC_LEN)-1:0] tidx_i,
  input  wire logic [7:0]                   tch_i,
  input  wire logic                         tfin_i,
  output logic                              tv_o,
  output logic      [$clog2(TOPIC_LEN)-1:0] tidx_o,
  output logic      [7:0]                   tch_o,
  output logic                              tfin_o,
  input  wire logic [$clog2(TOPIC_LEN)-1:0] plen_i,
  input  wire logic [31:0]                  ip_i,
  input  wire logic [15:0]                  port_i,
  input  wire logic                         cp_mode_i,
  input  wire logic [$clog2(TOPIC_LEN)-1:0] cp_addr_i,
  input  wire logic                         wr_en_i,
  input  wire logic [$clog2(TOPIC_LEN)-1:0] wr_addr_i,
  input  wire logic [7:0]                   wr_data_i,
  output logic      [7:0]                   rd_data_o,
  input  wire logic                         meta_we_i,
  input  wire logic [$clog2(TOPIC_LEN)-1:0] meta_len_i,
  input  wire logic [31:0]                  meta_ip_i,
  input  wire logic [15:0]                  meta_port_i,
  output logic      [$clog2(TOPIC_LEN)-1:0] meta_len_o,
  output logic      [31:0]                  meta_ip_o,
  output logic      [15:0]                  meta_port_o,
  output logic                              same_o,
  output logic                              hit_o
);
  import pstt_pkg::*;

  localparam int LW = $clog2(TOPIC_LEN);

  logic [7:0]    mem [TOPIC_LEN];
  logic [7:0]    rd_r;
  logic          tv_r;
  logic [LW-1:0] tidx_r;
  logic [7:0]    tch_r;
  logic          tfin_r;
  logic [LW-1:0] slen_r;
  logic [31:0]   ip_r;
  logic [15:0]   port_r;
  logic eq_r, any_r, early_r, lhash_r, slash_r, pre_r, tail_r;
  logic eq_nxt, any_nxt, early_nxt, lhash_nxt, slash_nxt, pre_nxt, tail_nxt;
  logic [LW:0]   j1, j2, slen_x;
  logic          pv, sv, init, s_hash, ceq;

  always_ff @(posedge clk) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_r <= mem[cp_mode_i ? cp_addr_i : tidx_i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r <= 1'b0;
    end else begin
      tv_r <= tv_i;
    end
  end

  always_ff @(posedge clk) begin
    tidx_r <= tidx_i;
    tch_r  <= tch_i;
    tfin_r <= tfin_i;
    if (meta_we_i) begin
      slen_r <= meta_len_i;
      ip_r   <= meta_ip_i;
      port_r <= meta_port_i;
    end
    if (tv_r) begin
      eq_r    <= eq_nxt;
      any_r   <= any_nxt;
      early_r <= early_nxt;
      lhash_r <= lhash_nxt;
      slash_r <= slash_nxt;
      pre_r   <= pre_nxt;
      tail_r  <= tail_nxt;
    end
  end

  always_comb begin
    j1     = {1'b0, tidx_r} + (LW+1)'(1);
    j2     = {1'b0, tidx_r} + (LW+1)'(2);
    slen_x = {1'b0, slen_r};
    pv     = tidx_r < plen_i;
    sv     = tidx_r < slen_r;
    init   = tidx_r == '0;
    s_hash = rd_r == CH_HASH;
    ceq    = rd_r == tch_r;
    eq_nxt    = (init | eq_r) & (!(sv & pv) | ceq);
    any_nxt   = (!init & any_r) | (sv & s_hash);
    early_nxt = (!init & early_r) | ((j1 < slen_x) & s_hash);
    lhash_nxt = (!init & lhash_r) | ((j1 == slen_x) & s_hash);
    slash_nxt = (!init & slash_r) | ((j2 == slen_x) & (rd_r == CH_SLASH));
    pre_nxt   = (init | pre_r) & (!(j2 < slen_x) | (pv & ceq));
    tail_nxt  = (!init & tail_r) |
                ((j2 == slen_x) & ((tidx_r == plen_i) | (pv & (tch_r == CH_SLASH))));
  end

  assign same_o = eq_r && (slen_r == plen_i) && (ip_r == ip_i) && (port_r == port_i);
  assign hit_o  = ((slen_r == LW'(1)) && lhash_r) ||
                  (any_r ? (lhash_r && !early_r && (slen_r >= LW'(2)) && slash_r &&
                            pre_r && tail_r)
                         : (eq_r && (slen_r == plen_i)));

  assign tv_o        = tv_r;
  assign tidx_o      = tidx_r;
  assign tch_o       = tch_r;
  assign tfin_o      = tfin_r;
  assign rd_data_o   = rd_r;
  assign meta_len_o  = slen_r;
  assign meta_ip_o   = ip_r;
  assign meta_port_o = port_r;

endmodule
`default_nettype wire

[hw/rtl/pstt_chk.sv]
`default_nettype none
module pstt_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_kind,
  input wire logic [31:0] out_dest_ip,
  input wire logic [15:0] out_dest_port,
  input wire logic [2:0]  out_status,
  input wire logic [4:0]  out_count,
  input wire logic        out_run_last
);
  import pstt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_dest_ip) &&
      $stable(out_dest_port) && $stable(out_status) && $stable(out_count))
    else $error("result changed while stalled");

  a_deliver: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DELIVER |-> !out_run_last && out_status == STS_ADDED &&
      out_count == 5'd0 && !in_ready)
    else $error("malformed delivery transfer");

  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DONE |-> out_run_last && out_dest_ip == 32'd0 &&
      out_dest_port == 16'd0 && out_status <= STS_TRUNC)
    else $error("malformed done transfer");

  a_sub_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DONE && (out_status == STS_ADDED ||
      out_status == STS_PRESENT || out_status == STS_FULL || out_status == STS_TRUNC)
      |-> out_count == 5'd0)
    else $error("nonzero count on a command that counts nothing");

endmodule

bind pubsub_topic_subscription_table pstt_chk u_pstt_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_kind     (out_kind),
  .out_dest_ip  (out_dest_ip),
  .out_dest_port(out_dest_port),
  .out_status   (out_status),
  .out_count    (out_count),
  .out_run_last (out_run_last)
);
`default_nettype wire
